>>> rtl/tcem_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcem_pkg: shared definitions for the touch coordinate event mapper
// Field widths, register indexes, controller kinds and event codes.
// ----------------------------------------------------------------------------
package tcem_pkg;

   localparam int SCREEN_DIM_MAX_DEF = 1024;

   localparam int RAW_W       = 16;
   localparam int STAT_W      = 8;
   localparam int TIME_W      = 32;
   localparam int POS_W       = 10;
   localparam int KIND_W      = 2;
   localparam int DIM_CFG_W   = 11;
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 56;
   localparam int RSP_PAD_W   = RSP_TDATA_W - 2 * POS_W - TIME_W;
   localparam int EV_W        = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   // status byte layout in scaled mode
   localparam int                STAT_READY_BIT  = 7;
   localparam logic [STAT_W-1:0] STAT_COUNT_MASK = 8'h0F;

   // controller kinds
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SCALED = 2'd2;

   // event codes
   localparam logic [EV_W-1:0] EV_DOWN = 2'd0;
   localparam logic [EV_W-1:0] EV_MOVE = 2'd1;
   localparam logic [EV_W-1:0] EV_UP   = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KIND   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PMAX_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PMAX_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCR_W  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCR_H  = 3'd5;

   // register reset values
   localparam logic [RAW_W-1:0]     PMAX_X_RST = 16'd480;
   localparam logic [RAW_W-1:0]     PMAX_Y_RST = 16'd272;
   localparam logic [DIM_CFG_W-1:0] SCR_W_RST  = 11'd480;
   localparam logic [DIM_CFG_W-1:0] SCR_H_RST  = 11'd272;

endpackage

>>> rtl/tcem_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcem_div: shared iterative restoring divider
// Produces QUOT_W quotient bits, one per cycle. The upper DIVISOR_W bits of
// the dividend must already be below the divisor, so the quotient fits.
// The divisor input is held stable by the caller while busy.
// ----------------------------------------------------------------------------
module tcem_div #(
   parameter int DIVISOR_W = 16,
   parameter int QUOT_W    = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIVISOR_W+QUOT_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        busy,
   output logic                        done,
   output logic [QUOT_W-1:0]           quotient
);

   localparam int CNT_W = $clog2(QUOT_W + 1);

   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [QUOT_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[QUOT_W-1]};
      diff    = trial - {1'b0, divisor};
      fits    = (trial >= {1'b0, divisor});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = dividend[DIVISOR_W+QUOT_W-1:QUOT_W];
         quo_in = dividend[QUOT_W-1:0];
         cnt_in = CNT_W'(QUOT_W);
      end else if (cnt_ff != '0) begin
         // quotient bits shift in where the dividend bits shift out
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign busy     = (cnt_ff != '0);
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/touch_coordinate_event_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_coordinate_event_mapper: touch poll to pointer event
// Scales or passes through panel coordinates, clamps them to the screen and
// emits down, move and up events.
//
//   port group  dir  payload
//   req_*       in   tdata: status_byte, raw_x, raw_y, time_ms
//                    tuser: status_read_ok, point_read_ok
//   rsp_*       out  tdata: pos_x, pos_y, event_time; tuser: event_kind
//   csr_*       in   register write, index 0..5
//
// A scaled touch goes from accept through the decode state, then per axis
// through a multiply step, a divider load step and the divide state in the
// shared divider, which serves both axes one quotient bit per cycle, and
// then through emit to the result register. Direct touches and releases go
// from decode to emit; a poll giving no event frees the input after decode.
// One transaction is worked on at a time; the next is accepted while a
// finished result still waits on rsp_tready, and a new result then holds in
// the emit state until the result register frees.
// Reset is synchronous; it restores settings and control state to defaults.
// ----------------------------------------------------------------------------
module touch_coordinate_event_mapper #(
   parameter int SCREEN_DIM_MAX = tcem_pkg::SCREEN_DIM_MAX_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // status_byte[7:0], raw_x[23:8], raw_y[39:24], time_ms[71:40]
   input  logic [tcem_pkg::REQ_TDATA_W-1:0] req_tdata,
   // status_read_ok[0], point_read_ok[1]
   input  logic [tcem_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // pos_x[9:0], pos_y[19:10], event_time[51:20], zero[55:52]
   output logic [tcem_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // event_kind[1:0]
   output logic [tcem_pkg::EV_W-1:0]        rsp_tuser,
   input  logic                             csr_wr_en,
   input  logic [tcem_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcem_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DIM_W  = $clog2(SCREEN_DIM_MAX + 1);
   localparam int RAW_W  = tcem_pkg::RAW_W;
   localparam int POS_W  = tcem_pkg::POS_W;
   localparam int PROD_W = RAW_W + DIM_W;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DECODE = 6'b000010,
      ST_MUL    = 6'b000100,
      ST_LOAD   = 6'b001000,
      ST_DIV    = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   // configuration
   logic [tcem_pkg::KIND_W-1:0]    kind_ff, kind_in;
   logic [RAW_W-1:0]               pmax_x_ff, pmax_x_in;
   logic [RAW_W-1:0]               pmax_y_ff, pmax_y_in;
   logic                           swap_ff, swap_in;
   logic [tcem_pkg::DIM_CFG_W-1:0] scr_w_ff, scr_w_in;
   logic [tcem_pkg::DIM_CFG_W-1:0] scr_h_ff, scr_h_in;

   // latched poll
   logic                           st_ok_ff, st_ok_in;
   logic                           pt_ok_ff, pt_ok_in;
   logic [tcem_pkg::STAT_W-1:0]    status_ff, status_in;
   logic [RAW_W-1:0]               raw_x_ff, raw_x_in;
   logic [RAW_W-1:0]               raw_y_ff, raw_y_in;
   logic [tcem_pkg::TIME_W-1:0]    time_ff, time_in;

   // work and event state
   state_type                      state_ff, state_in;
   logic                           axis_ff, axis_in;
   logic [POS_W-1:0]               res_x_ff, res_x_in;
   logic [POS_W-1:0]               res_y_ff, res_y_in;
   logic [tcem_pkg::EV_W-1:0]      ev_kind_ff, ev_kind_in;
   logic [PROD_W-1:0]              prod_ff, prod_in;
   logic [RAW_W-1:0]               divisor_ff, divisor_in;
   logic                           was_touched_ff, was_touched_in;
   logic [POS_W-1:0]               last_x_ff, last_x_in;
   logic [POS_W-1:0]               last_y_ff, last_y_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tcem_pkg::EV_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [POS_W-1:0]               rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]               rsp_y_ff, rsp_y_in;
   logic [tcem_pkg::TIME_W-1:0]    rsp_time_ff, rsp_time_in;

   logic [DIM_W-1:0]               w_eff;
   logic [DIM_W-1:0]               h_eff;
   logic [RAW_W-1:0]               ax_raw;
   logic [RAW_W-1:0]               ax_pmax;
   logic [RAW_W-1:0]               pmax_eff;
   logic [RAW_W-1:0]               raw_clamp;
   logic [DIM_W-1:0]               ax_dim;
   logic                           kind_ok;
   logic                           touched_scaled;
   logic                           touched_direct;
   logic                           emit_go;

   logic                           div_start;
   logic                           div_busy;
   logic                           div_done;
   logic [DIM_W-1:0]               div_quot;

   // signed direct coordinate limited to [0, dim-1]
   function automatic logic [POS_W-1:0] clamp_direct(input logic [RAW_W-1:0] v,
                                                     input logic [DIM_W-1:0] d);
      logic [RAW_W-1:0] r;
      begin
         if (v[RAW_W-1]) begin
            r = '0;
         end else if (v >= RAW_W'(d)) begin
            r = RAW_W'(d) - RAW_W'(1);
         end else begin
            r = v;
         end
         return POS_W'(r);
      end
   endfunction

   function automatic logic [DIM_W-1:0] sat_dim(input logic [tcem_pkg::DIM_CFG_W-1:0] d);
      begin
         if (d == '0) begin
            return DIM_W'(1);
         end else if (32'(d) > 32'(SCREEN_DIM_MAX)) begin
            return DIM_W'(SCREEN_DIM_MAX);
         end else begin
            return DIM_W'(d);
         end
      end
   endfunction

   tcem_div #(
      .DIVISOR_W (RAW_W),
      .QUOT_W    (DIM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (divisor_ff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // axis operand selection and panel clamp for the multiply step
   always_comb begin
      w_eff     = sat_dim(scr_w_ff);
      h_eff     = sat_dim(scr_h_ff);
      ax_raw    = (axis_ff ^ swap_ff) ? raw_y_ff : raw_x_ff;
      ax_pmax   = (axis_ff ^ swap_ff) ? pmax_y_ff : pmax_x_ff;
      ax_dim    = axis_ff ? h_eff : w_eff;
      pmax_eff  = (ax_pmax == '0) ? RAW_W'(ax_dim) : ax_pmax;
      raw_clamp = (ax_raw >= pmax_eff) ? (pmax_eff - RAW_W'(1)) : ax_raw;
   end

   always_comb begin
      kind_in   = kind_ff;
      pmax_x_in = pmax_x_ff;
      pmax_y_in = pmax_y_ff;
      swap_in   = swap_ff;
      scr_w_in  = scr_w_ff;
      scr_h_in  = scr_h_ff;
      if (csr_wr_en) begin
         case (csr_index)
            tcem_pkg::CSR_KIND:   kind_in   = csr_wdata[tcem_pkg::KIND_W-1:0];
            tcem_pkg::CSR_PMAX_X: pmax_x_in = csr_wdata[RAW_W-1:0];
            tcem_pkg::CSR_PMAX_Y: pmax_y_in = csr_wdata[RAW_W-1:0];
            tcem_pkg::CSR_SWAP:   swap_in   = csr_wdata[0];
            tcem_pkg::CSR_SCR_W:  scr_w_in  = csr_wdata[tcem_pkg::DIM_CFG_W-1:0];
            tcem_pkg::CSR_SCR_H:  scr_h_in  = csr_wdata[tcem_pkg::DIM_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      kind_ok        = (kind_ff == tcem_pkg::KIND_DIRECT) ||
                       (kind_ff == tcem_pkg::KIND_SCALED);
      touched_scaled = status_ff[tcem_pkg::STAT_READY_BIT] &&
                       ((status_ff & tcem_pkg::STAT_COUNT_MASK) != '0);
      touched_direct = (status_ff != '0);
      emit_go        = !rsp_valid_ff || rsp_tready;

      state_in       = state_ff;
      st_ok_in       = st_ok_ff;
      pt_ok_in       = pt_ok_ff;
      status_in      = status_ff;
      raw_x_in       = raw_x_ff;
      raw_y_in       = raw_y_ff;
      time_in        = time_ff;
      axis_in        = axis_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      ev_kind_in     = ev_kind_ff;
      prod_in        = prod_ff;
      divisor_in     = divisor_ff;
      was_touched_in = was_touched_ff;
      last_x_in      = last_x_ff;
      last_y_in      = last_y_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_time_in    = rsp_time_ff;
      div_start      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               st_ok_in  = req_tuser[0];
               pt_ok_in  = req_tuser[1];
               status_in = req_tdata[7:0];
               raw_x_in  = req_tdata[23:8];
               raw_y_in  = req_tdata[39:24];
               time_in   = req_tdata[71:40];
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_IDLE;
            if (kind_ok && st_ok_ff) begin
               if (kind_ff == tcem_pkg::KIND_SCALED && touched_scaled) begin
                  // failed point read drops the poll without touching state
                  if (pt_ok_ff) begin
                     ev_kind_in     = was_touched_ff ? tcem_pkg::EV_MOVE : tcem_pkg::EV_DOWN;
                     was_touched_in = 1'b1;
                     axis_in        = 1'b0;
                     state_in       = ST_MUL;
                  end
               end else if (kind_ff == tcem_pkg::KIND_DIRECT && touched_direct) begin
                  ev_kind_in     = was_touched_ff ? tcem_pkg::EV_MOVE : tcem_pkg::EV_DOWN;
                  was_touched_in = 1'b1;
                  res_x_in       = clamp_direct(raw_x_ff, w_eff);
                  res_y_in       = clamp_direct(raw_y_ff, h_eff);
                  state_in       = ST_EMIT;
               end else if (was_touched_ff) begin
                  ev_kind_in     = tcem_pkg::EV_UP;
                  was_touched_in = 1'b0;
                  res_x_in       = last_x_ff;
                  res_y_in       = last_y_ff;
                  state_in       = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            prod_in    = PROD_W'(raw_clamp) * PROD_W'(ax_dim);
            divisor_in = pmax_eff;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               // quotient stays below the screen size, no clamp needed
               if (!axis_ff) begin
                  res_x_in = POS_W'(div_quot);
                  axis_in  = 1'b1;
                  state_in = ST_MUL;
               end else begin
                  res_y_in = POS_W'(div_quot);
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = ev_kind_ff;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_time_in  = time_ff;
               last_x_in    = res_x_ff;
               last_y_in    = res_y_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      st_ok_in_reg: begin
         st_ok_ff    <= st_ok_in;
         pt_ok_ff    <= pt_ok_in;
         status_ff   <= status_in;
         raw_x_ff    <= raw_x_in;
         raw_y_ff    <= raw_y_in;
         time_ff     <= time_in;
         res_x_ff    <= res_x_in;
         res_y_ff    <= res_y_in;
         ev_kind_ff  <= ev_kind_in;
         prod_ff     <= prod_in;
         divisor_ff  <= divisor_in;
         rsp_kind_ff <= rsp_kind_in;
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_time_ff <= rsp_time_in;
      end
      if (reset) begin
         kind_ff        <= tcem_pkg::KIND_NONE;
         pmax_x_ff      <= tcem_pkg::PMAX_X_RST;
         pmax_y_ff      <= tcem_pkg::PMAX_Y_RST;
         swap_ff        <= 1'b0;
         scr_w_ff       <= tcem_pkg::SCR_W_RST;
         scr_h_ff       <= tcem_pkg::SCR_H_RST;
         state_ff       <= ST_IDLE;
         axis_ff        <= 1'b0;
         was_touched_ff <= 1'b0;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         kind_ff        <= kind_in;
         pmax_x_ff      <= pmax_x_in;
         pmax_y_ff      <= pmax_y_in;
         swap_ff        <= swap_in;
         scr_w_ff       <= scr_w_in;
         scr_h_ff       <= scr_h_in;
         state_ff       <= state_in;
         axis_ff        <= axis_in;
         was_touched_ff <= was_touched_in;
         last_x_ff      <= last_x_in;
         last_y_ff      <= last_y_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {{tcem_pkg::RSP_PAD_W{1'b0}}, rsp_time_ff, rsp_y_ff, rsp_x_ff};

   // divider only runs while the sequencer waits on it
   a_idle_div_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_busy)
      else $error("divider busy while idle");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider result outside the divide state");

   a_second_axis_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done && axis_ff) |=> state_ff == ST_EMIT)
      else $error("second axis did not lead to emit");

   a_emit_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("free result register not loaded on emit");

endmodule

>>> bench/touch_coordinate_event_mapper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_coordinate_event_mapper_tb: self-checking bench for the event mapper
// Streams touch polls into the block and keeps a predicted pointer event
// queue with its own copy of the settings and touch state. Every accepted
// event is compared field by field with the oldest prediction. A directed
// pass covers the edge cases, then randomized touch gestures run under
// several panel and screen settings. Both stream sides stall at random.
// ----------------------------------------------------------------------------
import tcem_pkg::*;

typedef struct {
   bit        st_ok;
   bit        pt_ok;
   bit [7:0]  status;
   bit [15:0] raw_x;
   bit [15:0] raw_y;
   bit [31:0] stamp;
} touch_poll_t;

typedef struct {
   bit [1:0]  ev_kind;
   bit [9:0]  pos_x;
   bit [9:0]  pos_y;
   bit [31:0] stamp;
} pointer_event_t;

typedef struct {
   bit [1:0]  kind;
   bit [15:0] pmax_x;
   bit [15:0] pmax_y;
   bit        swap;
   bit [10:0] scr_w;
   bit [10:0] scr_h;
} map_cfg_t;

class pointer_event_tracker;
   map_cfg_t       cfg;
   bit             touching;
   bit [9:0]       last_x;
   bit [9:0]       last_y;
   pointer_event_t pending_events[$];
   int unsigned    mismatches;

   function new();
      cfg.kind   = KIND_NONE;
      cfg.pmax_x = PMAX_X_RST;
      cfg.pmax_y = PMAX_Y_RST;
      cfg.swap   = 1'b0;
      cfg.scr_w  = SCR_W_RST;
      cfg.scr_h  = SCR_H_RST;
      touching   = 1'b0;
      last_x     = '0;
      last_y     = '0;
      mismatches = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_KIND:   cfg.kind   = val[KIND_W-1:0];
         CSR_PMAX_X: cfg.pmax_x = val;
         CSR_PMAX_Y: cfg.pmax_y = val;
         CSR_SWAP:   cfg.swap   = val[0];
         CSR_SCR_W:  cfg.scr_w  = val[DIM_CFG_W-1:0];
         CSR_SCR_H:  cfg.scr_h  = val[DIM_CFG_W-1:0];
         default: ;
      endcase
   endfunction

   // screen size saturated to 1..SCREEN_DIM_MAX
   function int unsigned clip_dim(bit [10:0] d);
      if (d == 0) return 1;
      if (d > SCREEN_DIM_MAX_DEF) return SCREEN_DIM_MAX_DEF;
      return d;
   endfunction

   function int scale_axis(bit [15:0] raw, bit [15:0] pmax, int unsigned dim);
      int unsigned divisor;
      int unsigned r;
      divisor = (pmax == 0) ? dim : pmax;
      r = raw;
      if (r >= divisor) r = divisor - 1;
      return int'((r * dim) / divisor);
   endfunction

   function bit [9:0] clamp_screen(int v, int unsigned dim);
      if (v < 0) return '0;
      if (v >= int'(dim)) return 10'(dim - 1);
      return 10'(v);
   endfunction

   function void note_poll(touch_poll_t p);
      int unsigned    w;
      int unsigned    h;
      int             sx;
      int             sy;
      bit             hit;
      pointer_event_t ev;
      w   = clip_dim(cfg.scr_w);
      h   = clip_dim(cfg.scr_h);
      hit = 1'b0;
      sx  = 0;
      sy  = 0;
      if (!(cfg.kind == KIND_DIRECT || cfg.kind == KIND_SCALED) || !p.st_ok) return;
      if (cfg.kind == KIND_SCALED) begin
         if (p.status[STAT_READY_BIT] && (p.status & STAT_COUNT_MASK) != 0) begin
            // touched but the point read failed: nothing changes
            if (!p.pt_ok) return;
            hit = 1'b1;
            if (cfg.swap) begin
               sx = scale_axis(p.raw_y, cfg.pmax_y, w);
               sy = scale_axis(p.raw_x, cfg.pmax_x, h);
            end else begin
               sx = scale_axis(p.raw_x, cfg.pmax_x, w);
               sy = scale_axis(p.raw_y, cfg.pmax_y, h);
            end
         end
      end else if (p.status != 0) begin
         hit = 1'b1;
         sx  = int'($signed(p.raw_x));
         sy  = int'($signed(p.raw_y));
      end
      ev.stamp = p.stamp;
      if (hit) begin
         ev.ev_kind = touching ? EV_MOVE : EV_DOWN;
         ev.pos_x   = clamp_screen(sx, w);
         ev.pos_y   = clamp_screen(sy, h);
         last_x     = ev.pos_x;
         last_y     = ev.pos_y;
         touching   = 1'b1;
         pending_events.push_back(ev);
      end else if (touching) begin
         ev.ev_kind = EV_UP;
         ev.pos_x   = last_x;
         ev.pos_y   = last_y;
         touching   = 1'b0;
         pending_events.push_back(ev);
      end
   endfunction

   function void check_event(logic [RSP_TDATA_W-1:0] data, logic [EV_W-1:0] user);
      pointer_event_t ev;
      logic [9:0]     px;
      logic [9:0]     py;
      logic [31:0]    t;
      px = data[POS_W-1:0];
      py = data[2*POS_W-1:POS_W];
      t  = data[2*POS_W+TIME_W-1:2*POS_W];
      if (pending_events.size() == 0) begin
         $error("unexpected event: event_kind %0d pos_x %0d pos_y %0d event_time %0d",
                user, px, py, t);
         mismatches++;
         return;
      end
      ev = pending_events.pop_front();
      if (user !== ev.ev_kind) begin
         $error("event_kind: expected %0d, actual %0d", ev.ev_kind, user);
         mismatches++;
      end
      if (px !== ev.pos_x) begin
         $error("pos_x: expected %0d, actual %0d", ev.pos_x, px);
         mismatches++;
      end
      if (py !== ev.pos_y) begin
         $error("pos_y: expected %0d, actual %0d", ev.pos_y, py);
         mismatches++;
      end
      if (t !== ev.stamp) begin
         $error("event_time: expected %0d, actual %0d", ev.stamp, t);
         mismatches++;
      end
   endfunction
endclass

module touch_coordinate_event_mapper_tb;

   localparam logic [KIND_W-1:0] KIND_UNUSED   = 2'd3;
   localparam int                SETTLE_CYCLES = 40;
   localparam int                STALL_LIMIT   = 2000;
   localparam int                PHASES        = 12;
   localparam int                PHASE_ITEMS   = 146;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [EV_W-1:0]        rsp_tuser;
   logic                   csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   pointer_event_tracker sb = new();
   bit                   steady = 1'b0;
   int unsigned          stalled_cycles = 0;

   touch_coordinate_event_mapper u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // event sink with random back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_event(rsp_tdata, rsp_tuser);
      rsp_tready <= steady || ($urandom_range(0, 99) >= 26);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_poll(input touch_poll_t p);
      int unsigned gap;
      gap = (!steady && $urandom_range(0, 99) < 26) ? $urandom_range(1, 4) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p.stamp, p.raw_y, p.raw_x, p.status};
      req_tuser  <= {p.pt_ok, p.st_ok};
      do @(posedge clock); while (!req_tready);
      sb.note_poll(p);
   endtask

   // stop sending and wait for every predicted event; optionally let a
   // poll that gives no event finish before the settings change
   task automatic drain_events(input bit settle);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_events.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.write_reg(idx, val);
   endtask

   task automatic apply_settings(input map_cfg_t c);
      drain_events(1'b1);
      csr_write(CSR_KIND, CSR_DATA_W'(c.kind));
      csr_write(CSR_PMAX_X, c.pmax_x);
      csr_write(CSR_PMAX_Y, c.pmax_y);
      csr_write(CSR_SWAP, CSR_DATA_W'(c.swap));
      csr_write(CSR_SCR_W, CSR_DATA_W'(c.scr_w));
      csr_write(CSR_SCR_H, CSR_DATA_W'(c.scr_h));
      csr_wr_en <= 1'b0;
   endtask

   function automatic touch_poll_t make_poll(bit st_ok, bit pt_ok, bit [7:0] status,
                                             bit [15:0] rx, bit [15:0] ry, bit [31:0] stamp);
      touch_poll_t p;
      p.st_ok  = st_ok;
      p.pt_ok  = pt_ok;
      p.status = status;
      p.raw_x  = rx;
      p.raw_y  = ry;
      p.stamp  = stamp;
      return p;
   endfunction

   function automatic map_cfg_t phase_settings(int ph);
      map_cfg_t c;
      c.kind   = $urandom_range(0, 1) ? KIND_DIRECT : KIND_SCALED;
      c.pmax_x = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 4096));
      c.pmax_y = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4096));
      c.swap   = 1'($urandom);
      c.scr_w  = ($urandom_range(0, 9) == 0) ? 11'($urandom) : 11'($urandom_range(1, 1024));
      c.scr_h  = 11'($urandom_range(1, 1024));
      case (ph)
         0: begin
            c.kind   = KIND_SCALED;
            c.pmax_x = 16'hFFFF;
            c.pmax_y = 16'hFFFF;
            c.swap   = 1'b0;
            c.scr_w  = 11'd1024;
            c.scr_h  = 11'd1024;
         end
         1: begin
            // zero panel maxima fall back to the screen size
            c.kind   = KIND_SCALED;
            c.pmax_x = 16'd0;
            c.pmax_y = 16'd0;
            c.swap   = 1'b1;
            c.scr_w  = 11'h7FF;
            c.scr_h  = 11'd0;
         end
         2: begin
            c.kind   = KIND_SCALED;
            c.pmax_x = 16'd1;
            c.pmax_y = 16'd1;
            c.swap   = 1'b1;
            c.scr_w  = 11'd1;
            c.scr_h  = 11'd1;
         end
         3: begin
            c.kind  = KIND_DIRECT;
            c.scr_w = 11'd1024;
            c.scr_h = 11'd1;
         end
         4: begin
            c.kind  = KIND_DIRECT;
            c.scr_w = 11'd0;
            c.scr_h = 11'h7FF;
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic bit [15:0] random_raw(int unsigned span, bit direct);
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) return 16'($urandom);
      if (sel == 2) return 16'(span - 1 + $urandom_range(0, 2));
      if (sel == 3 && direct) return 16'($urandom_range(32768, 65535));
      return 16'($urandom_range(0, span - 1));
   endfunction

   function automatic touch_poll_t random_poll(bit want_touch);
      touch_poll_t p;
      int unsigned w;
      int unsigned h;
      int unsigned span_x;
      int unsigned span_y;
      bit          direct;
      direct  = (sb.cfg.kind == KIND_DIRECT);
      w       = sb.clip_dim(sb.cfg.scr_w);
      h       = sb.clip_dim(sb.cfg.scr_h);
      p.st_ok = ($urandom_range(0, 19) != 0);
      p.pt_ok = direct ? 1'($urandom) : ($urandom_range(0, 19) != 0);
      p.stamp = $urandom;
      if (want_touch) begin
         p.status = direct ? 8'($urandom_range(1, 255))
                           : {1'b1, 3'($urandom), 4'($urandom_range(1, 15))};
      end else if (direct && $urandom_range(0, 4) != 0) begin
         p.status = 8'h00;
      end else begin
         case ($urandom_range(0, 2))
            0:       p.status = 8'h00;
            1:       p.status = {1'b0, 7'($urandom)};
            default: p.status = {1'b1, 3'($urandom), 4'h0};
         endcase
      end
      if (direct) begin
         span_x = w;
         span_y = h;
      end else begin
         // a zero maximum is replaced by the screen size it scales to
         span_x = (sb.cfg.pmax_x != 0) ? sb.cfg.pmax_x : (sb.cfg.swap ? h : w);
         span_y = (sb.cfg.pmax_y != 0) ? sb.cfg.pmax_y : (sb.cfg.swap ? w : h);
      end
      p.raw_x = random_raw(span_x, direct);
      p.raw_y = random_raw(span_y, direct);
      return p;
   endfunction

   initial begin
      map_cfg_t    dcfg;
      int unsigned sent;
      int unsigned n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // no panel after reset, then the unused kind: no events at all
      send_poll(make_poll(1'b1, 1'b1, 8'h81, 16'd100, 16'd100, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h01, 16'd5, 16'd5, $urandom));
      drain_events(1'b1);
      csr_write(CSR_KIND, CSR_DATA_W'(KIND_UNUSED));
      csr_wr_en <= 1'b0;
      send_poll(make_poll(1'b1, 1'b1, 8'hFF, 16'd10, 16'd20, $urandom));

      // scaled mode on the reset panel and screen sizes
      drain_events(1'b1);
      csr_write(CSR_KIND, CSR_DATA_W'(KIND_SCALED));
      csr_wr_en <= 1'b0;
      send_poll(make_poll(1'b1, 1'b1, 8'h81, 16'd0, 16'd0, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h8F, 16'd479, 16'd271, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h82, 16'hFFFF, 16'hFFFF, 32'd0));
      send_poll(make_poll(1'b1, 1'b0, 8'h81, 16'd12, 16'd34, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h05, 16'd12, 16'd34, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h80, 16'd12, 16'd34, $urandom));
      send_poll(make_poll(1'b0, 1'b1, 8'h81, 16'd12, 16'd34, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h81, 16'd240, 16'd136, 32'hFFFF_FFFF));
      send_poll(make_poll(1'b1, 1'b1, 8'hFF, 16'd480, 16'd272, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h80, 16'd0, 16'd0, $urandom));

      // direct mode: signed coordinates, clamp at both screen edges
      dcfg.kind   = KIND_DIRECT;
      dcfg.pmax_x = 16'd480;
      dcfg.pmax_y = 16'd272;
      dcfg.swap   = 1'b1;
      dcfg.scr_w  = 11'd1024;
      dcfg.scr_h  = 11'd1024;
      apply_settings(dcfg);
      send_poll(make_poll(1'b1, 1'b1, 8'h01, 16'h8000, 16'h7FFF, $urandom));
      send_poll(make_poll(1'b1, 1'b0, 8'h80, 16'hFFFF, 16'd0, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h40, 16'd1023, 16'd1024, $urandom));
      send_poll(make_poll(1'b1, 1'b1, 8'h00, 16'd7, 16'd7, $urandom));
      send_poll(make_poll(1'b0, 1'b0, 8'h00, 16'd7, 16'd7, $urandom));

      // random gestures: touch runs followed by releases, plus some noise
      for (int ph = 0; ph < PHASES; ph++) begin
         apply_settings(phase_settings(ph));
         steady = (ph == 3);
         sent   = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
               n = $urandom_range(1, 4);
               repeat (n) send_poll(random_poll(1'($urandom)));
               sent += n;
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) send_poll(random_poll(1'b1));
               sent += n;
               n = $urandom_range(1, 2);
               repeat (n) send_poll(random_poll(1'b0));
               sent += n;
            end
            if ($urandom_range(0, 99) < 5) drain_events(1'b0);
         end
         steady = 1'b0;
      end

      drain_events(1'b0);
      repeat (60) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
